FILE: rtl/ccd_pkg.sv
// ---------------------------------------------------------------------------
// ccd_pkg
// Shared types, tables and constants of the Cyrillic code page detector:
// the queue word between front and back, the result word, the KOI8-R letter
// table and the 32x32 letter pair bitmap.
// ---------------------------------------------------------------------------
package ccd_pkg;

    // Counter width default and fixed width of the hit outputs
    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int HIT_BITS           = 24;

    // Queue depths
    localparam int QUEUE_DEPTH  = 4;
    localparam int RESULT_DEPTH = 2;

    // Code page that scores a byte
    typedef enum logic [1:0] {
        PAGE_NONE = 2'd0,
        PAGE_WIN  = 2'd1,
        PAGE_KOI  = 2'd2,
        PAGE_DOS  = 2'd3
    } page_t;

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_ASCII   = 3'd0,
        VERDICT_CP1251  = 3'd1,
        VERDICT_CP866   = 3'd2,
        VERDICT_KOI8R   = 3'd3,
        VERDICT_UNKNOWN = 3'd4
    } verdict_t;

    // Classified byte, front to back
    typedef struct packed {
        page_t      page;
        logic [4:0] letter;   // letter code minus one
        logic       high;     // byte was 128 or more
        logic       last;     // last byte of the text
    } item_t;

    // Result word
    typedef struct packed {
        verdict_t              verdict;
        logic [HIT_BITS-1:0]   cp1251_hits;
        logic [HIT_BITS-1:0]   cp866_hits;
        logic [HIT_BITS-1:0]   koi8_hits;
    } result_t;

    // KOI8-R letter (code minus one) for the low five bits of bytes 0xC0 up
    localparam logic [4:0] KOI_LETTER [32] = '{
        5'd30, 5'd0,  5'd1,  5'd22, 5'd4,  5'd5,  5'd20, 5'd3,
        5'd21, 5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd31, 5'd16, 5'd17, 5'd18, 5'd19, 5'd6,  5'd2,
        5'd28, 5'd27, 5'd7,  5'd24, 5'd29, 5'd25, 5'd23, 5'd26
    };

    // Allowed pairs: row = previous letter, MSB = current letter 0
    localparam logic [31:0] PAIR_ROWS [32] = '{
        32'b11111111_11111111_11111111_11000111,
        32'b11111110_10111110_11110111_11111011,
        32'b11111101_10111111_11110111_11111001,
        32'b11111100_10111110_11110001_10000000,
        32'b11111111_11111111_11110111_10111011,
        32'b11111111_11111111_11111111_11001111,
        32'b11011110_10111111_11010001_00001000,
        32'b11111111_10111111_11110001_10111111,
        32'b11111111_11111111_11111111_11000111,
        32'b00011101_00111111_01111111_10000001,
        32'b10100111_10110110_11110010_10000010,
        32'b11111111_11111111_01110101_11011011,
        32'b11111100_10111111_11010111_10011101,
        32'b11111111_10101110_11111011_11011111,
        32'b11111111_11111111_11111111_11000111,
        32'b10000100_10110111_11110011_10011111,
        32'b11111111_11111111_11111111_11011011,
        32'b11111111_10111111_11111111_11111111,
        32'b11111101_10111111_11111111_11111111,
        32'b11111111_11111111_11100111_11000111,
        32'b10000100_10011110_11110000_00010010,
        32'b10111100_10111111_11110000_10000100,
        32'b10100100_10111010_00010000_00010000,
        32'b10100100_10111110_10111000_10001000,
        32'b10101100_10111111_11110111_00001010,
        32'b10000100_10000110_10010000_00001000,
        32'b00000100_00000000_00000000_00000011,
        32'b01111111_11111101_11110111_11000001,
        32'b01111101_10101110_01101111_11001011,
        32'b00010101_00011101_11111100_00000000,
        32'b01111111_01111101_11100111_11000010,
        32'b01111111_11111101_11110111_11000011
    };

    // Pair lookup
    function automatic logic pair_ok(input logic [4:0] prev, input logic [4:0] cur);
        logic [31:0] row;
        row = PAIR_ROWS[prev];
        return row[5'd31 - cur];
    endfunction

endpackage

FILE: rtl/ccd_fifo.sv
// ---------------------------------------------------------------------------
// ccd_fifo
// Small synchronous queue with full and empty flags; head word is shown
// combinationally while not empty.
// ---------------------------------------------------------------------------
module ccd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("ccd_fifo: fill count beyond depth");

endmodule

FILE: rtl/ccd_front.sv
// ---------------------------------------------------------------------------
// ccd_front
// Input stage: takes one text byte per cycle unless full, maps it to a letter
// code and the code page that scores it, and holds it until the queue takes it.
// ---------------------------------------------------------------------------
module ccd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    text_byte,
    input  logic          is_final,
    output logic          full,
    input  logic          q_full,
    output logic          q_push,
    output ccd_pkg::item_t q_item
);

    logic           valid_reg, valid_next;
    ccd_pkg::item_t item_reg;
    ccd_pkg::item_t item_cls;
    logic           take;

    assign full   = valid_reg && q_full;
    assign take   = push && !full;
    assign q_push = valid_reg;
    assign q_item = item_reg;

    // Classify: CP1251 first, then KOI8-R, then CP866
    always_comb
    begin
        item_cls.page   = ccd_pkg::PAGE_NONE;
        item_cls.letter = 5'd0;
        item_cls.high   = text_byte[7];
        item_cls.last   = is_final;
        if (text_byte >= 8'hC0)
        begin
            item_cls.page   = ccd_pkg::PAGE_WIN;
            item_cls.letter = text_byte[4:0];
        end
        else if (text_byte >= 8'hC0)
        begin
            // shadowed by CP1251, kept for the priority order
            item_cls.page   = ccd_pkg::PAGE_KOI;
            item_cls.letter = ccd_pkg::KOI_LETTER[text_byte[4:0]];
        end
        else if (text_byte[7:5] == 3'b100)
        begin
            item_cls.page   = ccd_pkg::PAGE_DOS;
            item_cls.letter = text_byte[4:0];
        end
        else if (text_byte[7:4] == 4'hA)
        begin
            item_cls.page   = ccd_pkg::PAGE_DOS;
            item_cls.letter = {1'b0, text_byte[3:0]};
        end
    end

    // Holding register valid
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!q_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_cls;
        end
    end

endmodule

FILE: rtl/ccd_back.sv
// ---------------------------------------------------------------------------
// ccd_back
// Scoring stage: keeps the previous letter and the saturating counters,
// snapshots them on the last byte of a text and forms the verdict.
// ---------------------------------------------------------------------------
module ccd_back #(
    parameter int COUNT_BITS = ccd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  ccd_pkg::item_t   q_item,
    output logic             q_pop,
    input  logic             res_full,
    output logic             res_push,
    output ccd_pkg::result_t res_word
);

    localparam int CB = COUNT_BITS;
    localparam int XW = COUNT_BITS + 4;
    localparam int OB = ccd_pkg::HIT_BITS;

    // Running state
    logic [4:0]    prev_reg, prev_next;
    logic          prev_valid_reg, prev_valid_next;
    logic          seen_reg, seen_next;
    logic [CB-1:0] win_reg, win_next;
    logic [CB-1:0] dos_reg, dos_next;
    logic [CB-1:0] koi_reg, koi_next;
    logic [CB-1:0] bytes_reg, bytes_next;

    // Snapshot of a finished text
    logic          snap_valid_reg, snap_valid_next;
    logic [CB-1:0] snap_win_reg, snap_dos_reg, snap_koi_reg, snap_bytes_reg;
    logic          snap_seen_reg;

    // Counts after the current byte
    logic [CB-1:0] win_upd, dos_upd, koi_upd, bytes_upd;
    logic          seen_upd;
    logic          hit, take, snap_free;

    logic [XW-1:0] win_x10, dos_x10, koi_x10, bytes_ext;
    logic [OB-1:0] win_out, dos_out, koi_out;

    assign snap_free = !snap_valid_reg || !res_full;
    assign take      = !q_empty && (!q_item.last || snap_free);
    assign q_pop     = take;
    assign res_push  = snap_valid_reg && !res_full;

    // Score the current byte
    always_comb
    begin
        hit       = prev_valid_reg && ccd_pkg::pair_ok(prev_reg, q_item.letter);
        win_upd   = win_reg;
        dos_upd   = dos_reg;
        koi_upd   = koi_reg;
        bytes_upd = (bytes_reg != '1) ? bytes_reg + 1'b1 : bytes_reg;
        seen_upd  = seen_reg || q_item.high;
        if (hit)
        begin
            case (q_item.page)
                ccd_pkg::PAGE_WIN: win_upd = (win_reg != '1) ? win_reg + 1'b1 : win_reg;
                ccd_pkg::PAGE_DOS: dos_upd = (dos_reg != '1) ? dos_reg + 1'b1 : dos_reg;
                ccd_pkg::PAGE_KOI: koi_upd = (koi_reg != '1) ? koi_reg + 1'b1 : koi_reg;
                default: ;
            endcase
        end
    end

    // Next state: clear at the end of a text
    always_comb
    begin
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        seen_next       = seen_reg;
        win_next        = win_reg;
        dos_next        = dos_reg;
        koi_next        = koi_reg;
        bytes_next      = bytes_reg;
        snap_valid_next = snap_valid_reg && !res_push;
        if (take)
        begin
            if (q_item.last)
            begin
                prev_next       = 5'd0;
                prev_valid_next = 1'b0;
                seen_next       = 1'b0;
                win_next        = '0;
                dos_next        = '0;
                koi_next        = '0;
                bytes_next      = '0;
                snap_valid_next = 1'b1;
            end
            else
            begin
                seen_next  = seen_upd;
                win_next   = win_upd;
                dos_next   = dos_upd;
                koi_next   = koi_upd;
                bytes_next = bytes_upd;
                if (q_item.page != ccd_pkg::PAGE_NONE)
                begin
                    prev_next       = q_item.letter;
                    prev_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= 5'd0;
            prev_valid_reg <= 1'b0;
            seen_reg       <= 1'b0;
            win_reg        <= '0;
            dos_reg        <= '0;
            koi_reg        <= '0;
            bytes_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            seen_reg       <= seen_next;
            win_reg        <= win_next;
            dos_reg        <= dos_next;
            koi_reg        <= koi_next;
            bytes_reg      <= bytes_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        if (take && q_item.last)
        begin
            snap_win_reg   <= win_upd;
            snap_dos_reg   <= dos_upd;
            snap_koi_reg   <= koi_upd;
            snap_bytes_reg <= bytes_upd;
            snap_seen_reg  <= seen_upd;
        end
    end

    // count > n/10 is the same as 10*count > n
    assign win_x10   = XW'({snap_win_reg, 3'b000}) + XW'({snap_win_reg, 1'b0});
    assign dos_x10   = XW'({snap_dos_reg, 3'b000}) + XW'({snap_dos_reg, 1'b0});
    assign koi_x10   = XW'({snap_koi_reg, 3'b000}) + XW'({snap_koi_reg, 1'b0});
    assign bytes_ext = XW'(snap_bytes_reg);

    // Verdict
    always_comb
    begin
        if (snap_win_reg > snap_dos_reg && snap_win_reg > snap_koi_reg
            && win_x10 > bytes_ext)
        begin
            res_word.verdict = ccd_pkg::VERDICT_CP1251;
        end
        else if (snap_dos_reg > snap_win_reg && snap_dos_reg > snap_koi_reg
                 && dos_x10 > bytes_ext)
        begin
            res_word.verdict = ccd_pkg::VERDICT_CP866;
        end
        else if (snap_koi_reg > snap_win_reg && snap_koi_reg > snap_dos_reg
                 && koi_x10 > bytes_ext)
        begin
            res_word.verdict = ccd_pkg::VERDICT_KOI8R;
        end
        else if (!snap_seen_reg)
        begin
            res_word.verdict = ccd_pkg::VERDICT_ASCII;
        end
        else
        begin
            res_word.verdict = ccd_pkg::VERDICT_UNKNOWN;
        end
        res_word.cp1251_hits = win_out;
        res_word.cp866_hits  = dos_out;
        res_word.koi8_hits   = koi_out;
    end

    // Each count onto the fixed-width hit fields, truncated or zero-extended
    generate
        if (CB >= OB)
        begin : g_trunc
            assign win_out = snap_win_reg[OB-1:0];
            assign dos_out = snap_dos_reg[OB-1:0];
            assign koi_out = snap_koi_reg[OB-1:0];
        end
        else
        begin : g_ext
            assign win_out = OB'(snap_win_reg);
            assign dos_out = OB'(snap_dos_reg);
            assign koi_out = OB'(snap_koi_reg);
        end
    endgenerate

    // Last byte clears the running state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_item.last |=> bytes_reg == '0 && !prev_valid_reg && !seen_reg)
        else $error("ccd_back: state not cleared after last byte");

    // Last byte always leaves a pending snapshot
    a_snap: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_item.last |=> snap_valid_reg)
        else $error("ccd_back: snapshot missing after last byte");

    // Saturating byte count never wraps to zero inside a text
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        take && !q_item.last |=> bytes_reg != '0)
        else $error("ccd_back: byte count wrapped");

endmodule

FILE: rtl/cyrillic_codepage_detector.sv
// ---------------------------------------------------------------------------
// cyrillic_codepage_detector
// Guesses the code page of a Cyrillic text from letter pair statistics.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive text_byte and is_final, raise push; the word is taken
//   at a clock edge with push high and full low. One byte per cycle is
//   sustained while full stays low. is_final marks the last byte of a text.
//   Result queue: while empty is low, verdict and the three hit counts of the
//   oldest finished text are on the outputs; pop with empty low takes it.
//   Only the last byte of a text yields a result word.
// Path: after its last byte is taken, a result passes the input register,
//   the byte queue, the scoring stage and the result queue.
// Throughput: 1 byte per cycle while full stays low; a result per cycle can
//   follow when every byte is a last byte and the result queue is not full.
// Stalls: when pop is held low the result queue fills, then the scoring
//   stage holds the next last byte, the byte queue fills and full rises.
//   Non-final bytes keep flowing while one result waits.
// Reset: rst_n clears the queues, the counters and the previous letter.
// ---------------------------------------------------------------------------
module cyrillic_codepage_detector #(
    parameter int COUNT_BITS = ccd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        is_final,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  verdict,
    output logic [23:0] cp1251_hits,
    output logic [23:0] cp866_hits,
    output logic [23:0] koi8_hits
);

    localparam int IW = $bits(ccd_pkg::item_t);
    localparam int RW = $bits(ccd_pkg::result_t);

    logic             q_push, q_full, q_empty, q_pop;
    ccd_pkg::item_t   q_in, q_out;
    logic [IW-1:0]    q_rdata;
    logic             res_push, res_full;
    ccd_pkg::result_t res_in, res_out;
    logic [RW-1:0]    res_rdata;

    // Front: accept and classify
    ccd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .is_final  (is_final),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    // Byte queue between front and back
    ccd_fifo #(
        .WIDTH (IW),
        .DEPTH (ccd_pkg::QUEUE_DEPTH)
    ) u_byte_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_in),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_out = ccd_pkg::item_t'(q_rdata);

    // Back: scoring and verdict
    ccd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_out),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_word (res_in)
    );

    // Result queue
    ccd_fifo #(
        .WIDTH (RW),
        .DEPTH (ccd_pkg::RESULT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (pop),
        .rdata (res_rdata),
        .full  (res_full),
        .empty (empty)
    );

    assign res_out     = ccd_pkg::result_t'(res_rdata);
    assign verdict     = res_out.verdict;
    assign cp1251_hits = res_out.cp1251_hits;
    assign cp866_hits  = res_out.cp866_hits;
    assign koi8_hits   = res_out.koi8_hits;

endmodule
